// ----- hw/rtl/kaf_pkg.sv -----
`default_nettype none
package kaf_pkg;

  localparam int IO_WIDTH  = 32;
  localparam int CFG_WIDTH = 24;
  localparam int IDX_WIDTH = 2;

  typedef logic [IDX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_STEP_PERIOD   = 2'd0;
  localparam cfg_index_t REG_ANGLE_NOISE   = 2'd1;
  localparam cfg_index_t REG_BIAS_NOISE    = 2'd2;
  localparam cfg_index_t REG_MEASURE_NOISE = 2'd3;

  localparam logic [15:0] STEP_PERIOD_RESET   = 16'd655;
  localparam logic [15:0] ANGLE_NOISE_RESET   = 16'd66;
  localparam logic [15:0] BIAS_NOISE_RESET    = 16'd197;
  localparam logic [23:0] MEASURE_NOISE_RESET = 24'd1966;

endpackage
`default_nettype wire

// ----- hw/rtl/kaf_channels.sv -----
`default_nettype none
interface kaf_in_if;
  logic valid;
  logic ready;
  logic signed [kaf_pkg::IO_WIDTH-1:0] gyro_rate;
  logic signed [kaf_pkg::IO_WIDTH-1:0] accel_angle;
  modport source (output valid, gyro_rate, accel_angle, input ready);
  modport sink (input valid, gyro_rate, accel_angle, output ready);
endinterface

interface kaf_out_if;
  logic valid;
  logic ready;
  logic signed [kaf_pkg::IO_WIDTH-1:0] angle_estimate;
  modport source (output valid, angle_estimate, input ready);
  modport sink (input valid, angle_estimate, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/kalman_angle_filter.sv -----
// Two-state angle / gyro-bias Kalman filter, signed fixed point throughout.
// sample channel: gyro_rate and accel_angle, one transfer per filter step.
// result channel: angle_estimate, the corrected angle after that step.
// cfg port: write enable, index (step_period, angle_noise, bias_noise,
// measure_noise) and data; write only while no step is in flight.
// One multiplier (registered result) and one saturating adder are shared by
// all steps under a sequencer; gains come from a restoring divider that
// produces one quotient bit per cycle.
// When the divisor is zero the divider is skipped and both gains are zero.
// Throughput: one sample per step; sample.ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next sample is taken while it waits; if the receiver still stalls when the
// following step completes, the sequencer holds until the register drains.
// Reset clears estimates to zero, covariance to identity, registers to their
// defaults, and empties the output register.
`default_nettype none
module kalman_angle_filter #(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  kaf_in_if.sink                             sample,
  kaf_out_if.source                          result,
  input  wire logic                          cfg_write,
  input  wire logic [kaf_pkg::IDX_WIDTH-1:0] cfg_index,
  input  wire logic [kaf_pkg::CFG_WIDTH-1:0] cfg_data
);
  import kaf_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int XW  = ((W > IO_WIDTH) ? W : IO_WIDTH) + 2;
  localparam int RW  = ((W > CFG_WIDTH) ? W : CFG_WIDTH) + 1;
  localparam int DN  = W + F;
  localparam int CW  = $clog2(DN + 1);
  localparam int PW  = 2 * W + 1;
  localparam int MW  = PW - F;

  localparam logic signed [XW-1:0] XMAX = $signed({{(XW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [XW-1:0] XMIN = -XMAX - XW'(1);
  localparam logic signed [XW-1:0] OMAX =
    $signed({{(XW-IO_WIDTH+1){1'b0}}, {(IO_WIDTH-1){1'b1}}});
  localparam logic signed [XW-1:0] OMIN = -OMAX - XW'(1);
  localparam logic [RW-1:0] RMAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [W:0] HALF = {2'b01, {(W-1){1'b0}}};
  localparam logic [W-1:0] QSTUCK = {1'b1, {(W-2){1'b0}}, 1'b1};

  localparam logic [4:0] S_IDLE  = 5'd0,  S_RATE = 5'd1,  S_MRATE = 5'd2,  S_PA   = 5'd3,
                         S_MDP   = 5'd4,  S_IN1  = 5'd5,  S_IN2   = 5'd6,  S_IN3  = 5'd7,
                         S_MIN   = 5'd8,  S_P00  = 5'd9,  S_P01   = 5'd10, S_P10  = 5'd11,
                         S_MQB   = 5'd12, S_P11  = 5'd13, S_INNOV = 5'd14, S_SVAR = 5'd15,
                         S_DIV   = 5'd16, S_MK0Y = 5'd17, S_ANG   = 5'd18, S_MK1Y = 5'd19,
                         S_BIAS  = 5'd20, S_MC2  = 5'd21, S_C2    = 5'd22, S_MC3  = 5'd23,
                         S_C3    = 5'd24, S_MC0  = 5'd25, S_C0    = 5'd26, S_MC1  = 5'd27,
                         S_C1    = 5'd28, S_DONE = 5'd29;

  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
    if (v > XMAX) return XMAX[W-1:0];
    if (v < XMIN) return XMIN[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] from_reg(input logic [CFG_WIDTH-1:0] v);
    logic [RW-1:0] e;
    e = RW'(v);
    if (e > RMAX) return RMAX[W-1:0];
    return e[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? -v : v;
  endfunction

  function automatic logic signed [W-1:0] apply_sign(input logic [MW-1:0] m, input logic neg);
    logic [MW-1:0] cap;
    logic [MW-1:0] mc;
    cap = neg ? MW'(HALF) : MW'(HALF) - MW'(1);
    mc  = (m > cap) ? cap : m;
    return neg ? -mc[W-1:0] : mc[W-1:0];
  endfunction

  logic [15:0] step_period, angle_noise, bias_noise;
  logic [23:0] measure_noise;
  logic [4:0]  state;

  logic signed [W-1:0] g, z, ang, bias, p00, p01, p10, p11;
  logic signed [W-1:0] tmp, pa, dtp, y, s, k0, k1, mres;
  logic signed [W-1:0] dt, qa, qb, rn;

  // shared saturating adder and multiplier operands
  logic signed [W-1:0] add_a, add_b, add_res, mul_a, mul_b;
  logic                add_sub;

  // divider
  logic [DN-1:0]  dsr;
  logic [W-1:0]   rem, dvs, quo;
  logic           dneg, dover, dsel;
  logic [CW-1:0]  dcnt;
  logic [W:0]     r_sh, q_sh;
  logic           r_ge, q_over;
  logic [MW-1:0]  q_ext;

  assign dt = from_reg(CFG_WIDTH'(step_period));
  assign qa = from_reg(CFG_WIDTH'(angle_noise));
  assign qb = from_reg(CFG_WIDTH'(bias_noise));
  assign rn = from_reg(measure_noise);

  assign sample.ready = (state == S_IDLE);

  always_comb begin
    add_a   = ang;
    add_b   = mres;
    add_sub = 1'b0;
    mul_a   = dt;
    mul_b   = p11;
    unique case (state)
      S_RATE:  begin add_a = g;    add_b = bias; add_sub = 1'b1; end
      S_PA:    begin add_a = ang;  add_b = mres; end
      S_IN1:   begin add_a = mres; add_b = p01;  add_sub = 1'b1; end
      S_IN2:   begin add_a = tmp;  add_b = p10;  add_sub = 1'b1; end
      S_IN3:   begin add_a = tmp;  add_b = qa;   end
      S_P00:   begin add_a = p00;  add_b = mres; end
      S_P01:   begin add_a = p01;  add_b = dtp;  add_sub = 1'b1; end
      S_P10:   begin add_a = p10;  add_b = dtp;  add_sub = 1'b1; end
      S_P11:   begin add_a = p11;  add_b = mres; end
      S_INNOV: begin add_a = z;    add_b = pa;   add_sub = 1'b1; end
      S_SVAR:  begin add_a = p00;  add_b = rn;   end
      S_ANG:   begin add_a = pa;   add_b = mres; end
      S_BIAS:  begin add_a = bias; add_b = mres; end
      S_C2:    begin add_a = p10;  add_b = mres; add_sub = 1'b1; end
      S_C3:    begin add_a = p11;  add_b = mres; add_sub = 1'b1; end
      S_C0:    begin add_a = p00;  add_b = mres; add_sub = 1'b1; end
      S_C1:    begin add_a = p01;  add_b = mres; add_sub = 1'b1; end
      default: begin end
    endcase
    unique case (state)
      S_MRATE: begin mul_a = tmp; mul_b = dt;  end
      S_MIN:   begin mul_a = dt;  mul_b = tmp; end
      S_MQB:   begin mul_a = dt;  mul_b = qb;  end
      S_MK0Y:  begin mul_a = k0;  mul_b = y;   end
      S_MK1Y:  begin mul_a = k1;  mul_b = y;   end
      S_MC2:   begin mul_a = k1;  mul_b = p00; end
      S_MC3:   begin mul_a = k1;  mul_b = p01; end
      S_MC0:   begin mul_a = k0;  mul_b = p00; end
      S_MC1:   begin mul_a = k0;  mul_b = p01; end
      default: begin end
    endcase
  end

  assign add_res = add_sub ? sat_w(XW'(add_a) - XW'(add_b)) : sat_w(XW'(add_a) + XW'(add_b));

  // restoring divide step
  assign r_sh   = {rem, dsr[DN-1]};
  assign r_ge   = r_sh >= {1'b0, dvs};
  assign q_sh   = {quo, r_ge};
  assign q_over = dover || (q_sh > HALF);
  assign q_ext  = MW'(quo);

  always_ff @(posedge clk) begin
    logic [W-1:0]   ma, mb;
    logic [2*W-1:0] prod;
    logic [PW-1:0]  rnd;
    ma   = mag(mul_a);
    mb   = mag(mul_b);
    prod = ma * mb;
    rnd  = PW'(prod) + (PW'(1) << (F - 1));
    mres <= apply_sign(rnd[PW-1:F], mul_a[W-1] ^ mul_b[W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period   <= STEP_PERIOD_RESET;
      angle_noise   <= ANGLE_NOISE_RESET;
      bias_noise    <= BIAS_NOISE_RESET;
      measure_noise <= MEASURE_NOISE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_PERIOD:   step_period   <= cfg_data[15:0];
        REG_ANGLE_NOISE:   angle_noise   <= cfg_data[15:0];
        REG_BIAS_NOISE:    bias_noise    <= cfg_data[15:0];
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ang          <= '0;
      bias         <= '0;
      p00          <= sat_w(XW'(1) <<< F);
      p01          <= '0;
      p10          <= '0;
      p11          <= sat_w(XW'(1) <<< F);
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_DONE) result.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (sample.valid) begin
          g     <= sat_w(XW'(sample.gyro_rate));
          z     <= sat_w(XW'(sample.accel_angle));
          state <= S_RATE;
        end
        S_RATE:  begin tmp <= add_res; state <= S_MRATE; end
        S_MRATE: state <= S_PA;
        S_PA:    begin pa <= add_res; state <= S_MDP; end
        S_MDP:   state <= S_IN1;
        S_IN1:   begin tmp <= add_res; dtp <= mres; state <= S_IN2; end
        S_IN2:   begin tmp <= add_res; state <= S_IN3; end
        S_IN3:   begin tmp <= add_res; state <= S_MIN; end
        S_MIN:   state <= S_P00;
        S_P00:   begin p00 <= add_res; state <= S_P01; end
        S_P01:   begin p01 <= add_res; state <= S_P10; end
        S_P10:   begin p10 <= add_res; state <= S_MQB; end
        S_MQB:   state <= S_P11;
        S_P11:   begin p11 <= add_res; state <= S_INNOV; end
        S_INNOV: begin y <= add_res; state <= S_SVAR; end
        S_SVAR: begin
          s <= add_res;
          if (add_res == '0) begin
            k0    <= '0;
            k1    <= '0;
            state <= S_MK0Y;
          end else begin
            dsr   <= {mag(p00), {F{1'b0}}};
            dvs   <= mag(add_res);
            dneg  <= p00[W-1] ^ add_res[W-1];
            rem   <= '0;
            quo   <= '0;
            dover <= 1'b0;
            dcnt  <= '0;
            dsel  <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == CW'(DN)) begin
            if (!dsel) begin
              k0    <= apply_sign(dover ? MW'(HALF) + MW'(1) : q_ext, dneg);
              dsr   <= {mag(p10), {F{1'b0}}};
              dneg  <= p10[W-1] ^ s[W-1];
              rem   <= '0;
              quo   <= '0;
              dover <= 1'b0;
              dcnt  <= '0;
              dsel  <= 1'b1;
            end else begin
              k1    <= apply_sign(dover ? MW'(HALF) + MW'(1) : q_ext, dneg);
              state <= S_MK0Y;
            end
          end else begin
            dsr   <= dsr << 1;
            rem   <= r_ge ? W'(r_sh - {1'b0, dvs}) : r_sh[W-1:0];
            quo   <= q_over ? QSTUCK : q_sh[W-1:0];
            dover <= q_over;
            dcnt  <= dcnt + CW'(1);
          end
        end
        S_MK0Y: state <= S_ANG;
        S_ANG:  begin ang <= add_res; state <= S_MK1Y; end
        S_MK1Y: state <= S_BIAS;
        S_BIAS: begin bias <= add_res; state <= S_MC2; end
        S_MC2:  state <= S_C2;
        S_C2:   begin p10 <= add_res; state <= S_MC3; end
        S_MC3:  state <= S_C3;
        S_C3:   begin p11 <= add_res; state <= S_MC0; end
        S_MC0:  state <= S_C0;
        S_C0:   begin p00 <= add_res; state <= S_MC1; end
        S_MC1:  state <= S_C1;
        S_C1:   begin p01 <= add_res; state <= S_DONE; end
        S_DONE: if (!result.valid || result.ready) begin
          result.valid <= 1'b1;
          if (XW'(ang) > OMAX) result.angle_estimate <= OMAX[IO_WIDTH-1:0];
          else if (XW'(ang) < OMIN) result.angle_estimate <= OMIN[IO_WIDTH-1:0];
          else result.angle_estimate <= IO_WIDTH'(XW'(ang));
          state <= S_IDLE;
        end else if (result.valid && result.ready) begin
          result.valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/kalman_angle_filter_tb.sv -----
`default_nettype none
module kalman_angle_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kaf_pkg::*;

  localparam longint WORD_MAX   = 64'sd2147483647;
  localparam longint WORD_MIN   = -64'sd2147483648;
  localparam int     DRAIN_WAIT = 160;
  localparam int     CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] gyro;
    logic signed [31:0] accel;
    bit                 typed;
    logic signed [31:0] angle;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data  = '0;

  kaf_in_if  sample_ch ();
  kaf_out_if result_ch ();

  kalman_angle_filter dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // filter state and register copies
  longint dt_reg, qa_reg, qb_reg, r_reg;
  longint angle_est, bias_est;
  longint cov[4];

  logic signed [31:0] angle_queue[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm_mode = 1'b0;

  sample_row_t directed_rows[] = '{
    '{32'sd0, 32'sd0, 1'b1, 32'sd0},
    '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sd0},
    '{32'sh80000000, 32'sh80000000, 1'b0, 32'sd0},
    '{32'sh7fffffff, 32'sh80000000, 1'b0, 32'sd0},
    '{32'sh80000000, 32'sh7fffffff, 1'b0, 32'sd0},
    '{32'sd0, 32'sh7fffffff, 1'b0, 32'sd0},
    '{32'sd0, 32'sh80000000, 1'b0, 32'sd0},
    '{32'sh55555555, 32'shaaaaaaaa, 1'b0, 32'sd0},
    '{32'shaaaaaaaa, 32'sh55555555, 1'b0, 32'sd0},
    '{32'sd1, -32'sd1, 1'b0, 32'sd0},
    '{-32'sd1, 32'sd1, 1'b0, 32'sd0},
    '{32'sd65536, 32'sd65536, 1'b0, 32'sd0},
    '{-32'sd65536, -32'sd131072, 1'b0, 32'sd0},
    '{32'sd0, 32'sd0, 1'b0, 32'sd0}
  };

  function automatic longint clamp(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint cap_signed(longint unsigned m, bit neg);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // round half away from zero on the magnitude
  function automatic longint qmul(longint a, longint b);
    longint unsigned ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    return cap_signed((ma * mb + 64'd32768) >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic longint qdiv(longint a, longint b);
    longint unsigned ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    return cap_signed((ma << 16) / mb, (a < 0) != (b < 0));
  endfunction

  function automatic logic signed [31:0] filter_step(logic signed [31:0] g,
                                                     logic signed [31:0] z);
    longint p00, p01, p10, p11, rate, pa, inner, y, s, k0, k1;
    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    k0 = 0;
    k1 = 0;
    rate  = clamp(longint'(g) - bias_est);
    pa    = clamp(angle_est + qmul(rate, dt_reg));
    inner = clamp(qmul(dt_reg, p11) - p01);
    inner = clamp(inner - p10);
    inner = clamp(inner + qa_reg);
    p00 = clamp(p00 + qmul(dt_reg, inner));
    p01 = clamp(p01 - qmul(dt_reg, p11));
    p10 = clamp(p10 - qmul(dt_reg, p11));
    p11 = clamp(p11 + qmul(dt_reg, qb_reg));
    y = clamp(longint'(z) - pa);
    s = clamp(p00 + r_reg);
    if (s != 0) begin
      k0 = qdiv(p00, s);
      k1 = qdiv(p10, s);
    end
    angle_est = clamp(pa + qmul(k0, y));
    bias_est  = clamp(bias_est + qmul(k1, y));
    cov[0] = clamp(p00 - qmul(k0, p00));
    cov[1] = clamp(p01 - qmul(k0, p01));
    cov[2] = clamp(p10 - qmul(k1, p00));
    cov[3] = clamp(p11 - qmul(k1, p01));
    return angle_est[31:0];
  endfunction

  function automatic int draw_gap();
    if (calm_mode || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic send_sample(logic signed [31:0] g, logic signed [31:0] z,
                             bit typed, logic signed [31:0] typed_angle);
    int gap;
    logic signed [31:0] predicted;
    gap = draw_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.gyro_rate   <= g;
    sample_ch.accel_angle <= z;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = filter_step(g, z);
    angle_queue.push_back(typed ? typed_angle : predicted);
  endtask

  // hold until idle, then write all four registers back to back
  task automatic set_filter(longint dt, longint qa, longint qb, longint r);
    logic [CFG_WIDTH-1:0] vals[4];
    cfg_index_t idx[4];
    sample_ch.valid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    vals = '{dt[23:0], qa[23:0], qb[23:0], r[23:0]};
    idx  = '{REG_STEP_PERIOD, REG_ANGLE_NOISE, REG_BIAS_NOISE, REG_MEASURE_NOISE};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    dt_reg = dt & 64'hffff;
    qa_reg = qa & 64'hffff;
    qb_reg = qb & 64'hffff;
    r_reg  = r & 64'hffffff;
  endtask

  task automatic random_samples(int count);
    logic signed [31:0] g, z;
    int kind;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) calm_mode = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // plausible motion: accel near the tracked angle, modest rate
        g = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        z = 32'(clamp(angle_est + $signed($urandom_range(0, 1 << 18)) - (1 << 17)));
      end else if (kind == 7) begin
        g = $urandom();
        z = $urandom();
      end else if (kind == 8) begin
        g = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        z = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      end else begin
        g = 32'sd1 <<< $urandom_range(0, 31);
        z = ~(32'sd1 <<< $urandom_range(0, 31));
      end
      send_sample(g, z, 1'b0, 32'sd0);
    end
  endtask

  initial begin
    sample_ch.valid       = 1'b0;
    sample_ch.gyro_rate   = '0;
    sample_ch.accel_angle = '0;
    result_ch.ready       = 1'b0;
    dt_reg = longint'(STEP_PERIOD_RESET);
    qa_reg = longint'(ANGLE_NOISE_RESET);
    qb_reg = longint'(BIAS_NOISE_RESET);
    r_reg  = longint'(MEASURE_NOISE_RESET);
    angle_est = 0;
    bias_est  = 0;
    cov = '{65536, 0, 0, 65536};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].gyro, directed_rows[i].accel,
                  directed_rows[i].typed, directed_rows[i].angle);

    random_samples(150);
    set_filter(65535, 65535, 65535, 24'hffffff);
    random_samples(150);
    set_filter(1, 0, 0, 1);
    random_samples(150);
    set_filter(0, 0, 0, 0);
    random_samples(100);
    set_filter(655, 66, 197, 1966);
    random_samples(150);
    for (int ph = 0; ph < 4; ph++) begin
      set_filter($urandom_range(1, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(1, 24'hffffff));
      random_samples(150);
    end

    sample_ch.valid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("kalman_angle_filter test passed");
    end else begin
      $display("kalman_angle_filter test failed");
    end
    $finish;
  end

  // result side: random stall, then accept one transfer
  initial begin
    int gap;
    logic signed [31:0] want;
    @(negedge rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      if (angle_queue.size() == 0) begin
        $error("unexpected angle_estimate transfer: %0d", result_ch.angle_estimate);
        errors++;
      end else begin
        want = angle_queue.pop_front();
        if (result_ch.angle_estimate !== want) begin
          $error("angle_estimate: expected %0d, actual %0d",
                 want, result_ch.angle_estimate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("kalman_angle_filter test failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
